FILE: rtl/pairwise_gravity_force_core_assert.svh
// Assertion macros for the pairwise gravity force core.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef PAIRWISE_GRAVITY_FORCE_CORE_ASSERT_SVH
`define PAIRWISE_GRAVITY_FORCE_CORE_ASSERT_SVH

// same-cycle implication
`define PGF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pgf_pkg.sv
// Shared types and constants for the pairwise gravity force core.
// No dependencies.
package pgf_pkg;

    localparam int PGF_ID_BITS    = 10;
    localparam int PGF_POS_W      = 32;
    localparam int PGF_MASS_W     = 32;
    localparam int PGF_RAD_W      = 31;
    localparam int PGF_GAIN_W     = 32;
    localparam int PGF_ESC_W      = 31;
    localparam int PGF_ESC_SQ_W   = 2 * PGF_ESC_W;
    localparam int PGF_FORCE_W    = 48;
    localparam int PGF_DIFF_W     = PGF_POS_W + 1;
    localparam int PGF_D2_W       = 66;
    localparam int PGF_ROOT_W     = PGF_D2_W / 2;
    localparam int PGF_NUM_W      = PGF_GAIN_W + 2 * PGF_MASS_W + 16;
    localparam int PGF_FM_QW      = 81;
    localparam int PGF_FM_W       = PGF_FM_QW + 1;
    localparam int PGF_P_W        = PGF_FM_W + PGF_DIFF_W;
    localparam int PGF_CFG_IDX_W  = 8;
    localparam int PGF_CFG_DATA_W = 32;

    typedef enum logic [PGF_CFG_IDX_W-1:0] {
        CFG_GRAV_GAIN     = 8'd0,
        CFG_ESCAPE_RADIUS = 8'd1
    } t_cfg_reg;

    typedef struct packed {
        logic force_valid;
        logic collided;
        logic escaped;
    } t_flags;

    typedef struct packed {
        logic        [PGF_D2_W-1:0]   d2;
        logic        [PGF_NUM_W-1:0]  num;
        logic signed [PGF_DIFF_W-1:0] dx;
        logic signed [PGF_DIFF_W-1:0] dy;
        logic signed [PGF_DIFF_W-1:0] dz;
        t_flags                       flags;
    } t_sqrt_tag;

    typedef struct packed {
        logic        [PGF_ROOT_W-1:0] dr;
        logic signed [PGF_DIFF_W-1:0] dx;
        logic signed [PGF_DIFF_W-1:0] dy;
        logic signed [PGF_DIFF_W-1:0] dz;
        t_flags                       flags;
    } t_fmdiv_tag;

    typedef struct packed {
        logic   neg;
        logic   kill;
        t_flags flags;
    } t_axis_tag;

    typedef struct packed {
        logic signed [PGF_FORCE_W-1:0] force_x;
        logic signed [PGF_FORCE_W-1:0] force_y;
        logic signed [PGF_FORCE_W-1:0] force_z;
        t_flags                        flags;
    } t_result;

endpackage

FILE: rtl/pgf_if.sv
// Valid/ready channel interfaces: pair request, result, configuration write.
// Depends on pgf_pkg.
interface pgf_in_if #(parameter int ID_BITS = pgf_pkg::PGF_ID_BITS);
    logic                                 valid;
    logic                                 ready;
    logic [ID_BITS-1:0]                   target_id;
    logic [ID_BITS-1:0]                   source_id;
    logic signed [pgf_pkg::PGF_POS_W-1:0] target_x;
    logic signed [pgf_pkg::PGF_POS_W-1:0] target_y;
    logic signed [pgf_pkg::PGF_POS_W-1:0] target_z;
    logic signed [pgf_pkg::PGF_POS_W-1:0] source_x;
    logic signed [pgf_pkg::PGF_POS_W-1:0] source_y;
    logic signed [pgf_pkg::PGF_POS_W-1:0] source_z;
    logic [pgf_pkg::PGF_MASS_W-1:0]       target_mass;
    logic [pgf_pkg::PGF_MASS_W-1:0]       source_mass;
    logic [pgf_pkg::PGF_RAD_W-1:0]        target_radius;
    logic [pgf_pkg::PGF_RAD_W-1:0]        source_radius;

    modport source (output valid, target_id, source_id, target_x, target_y, target_z,
                    source_x, source_y, source_z, target_mass, source_mass,
                    target_radius, source_radius, input ready);
    modport sink   (input valid, target_id, source_id, target_x, target_y, target_z,
                    source_x, source_y, source_z, target_mass, source_mass,
                    target_radius, source_radius, output ready);
endinterface

interface pgf_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pgf_pkg::PGF_FORCE_W-1:0] force_x;
    logic signed [pgf_pkg::PGF_FORCE_W-1:0] force_y;
    logic signed [pgf_pkg::PGF_FORCE_W-1:0] force_z;
    logic                                   force_valid;
    logic                                   collided;
    logic                                   escaped;

    modport source (output valid, force_x, force_y, force_z, force_valid, collided,
                    escaped, input ready);
    modport sink   (input valid, force_x, force_y, force_z, force_valid, collided,
                    escaped, output ready);
endinterface

interface pgf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pgf_pkg::PGF_CFG_IDX_W-1:0]   index;
    logic [pgf_pkg::PGF_CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pgf_front.sv
// Front end: differences, squares, mass/gain product, flags (four stages).
// Depends on pgf_pkg.
module pgf_front #(
    parameter int ID_BITS = pgf_pkg::PGF_ID_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_ce,
    input  logic                                  i_vld,
    input  logic [ID_BITS-1:0]                    i_target_id,
    input  logic [ID_BITS-1:0]                    i_source_id,
    input  logic signed [pgf_pkg::PGF_POS_W-1:0]  i_target_x,
    input  logic signed [pgf_pkg::PGF_POS_W-1:0]  i_target_y,
    input  logic signed [pgf_pkg::PGF_POS_W-1:0]  i_target_z,
    input  logic signed [pgf_pkg::PGF_POS_W-1:0]  i_source_x,
    input  logic signed [pgf_pkg::PGF_POS_W-1:0]  i_source_y,
    input  logic signed [pgf_pkg::PGF_POS_W-1:0]  i_source_z,
    input  logic [pgf_pkg::PGF_MASS_W-1:0]        i_target_mass,
    input  logic [pgf_pkg::PGF_MASS_W-1:0]        i_source_mass,
    input  logic [pgf_pkg::PGF_RAD_W-1:0]         i_target_radius,
    input  logic [pgf_pkg::PGF_RAD_W-1:0]         i_source_radius,
    input  logic [pgf_pkg::PGF_GAIN_W-1:0]        i_grav_gain,
    input  logic [pgf_pkg::PGF_ESC_SQ_W-1:0]      i_esc_sq,
    output logic                                  o_vld,
    output pgf_pkg::t_sqrt_tag                    o_data
);
    import pgf_pkg::*;

    // stage 1
    logic                         r1_vld;
    logic signed [PGF_DIFF_W-1:0] r1_dx, r1_dy, r1_dz;
    logic                         r1_same;
    logic [PGF_RAD_W:0]           r1_rsum;
    logic signed [PGF_POS_W-1:0]  r1_tx, r1_ty, r1_tz;
    logic [2*PGF_MASS_W-1:0]      r1_mass;
    // stage 2
    logic                         r2_vld;
    logic [2*PGF_POS_W:0]         r2_sqx, r2_sqy, r2_sqz;
    logic [2*PGF_RAD_W+1:0]       r2_rs2;
    logic [2*PGF_POS_W-2:0]       r2_tsx, r2_tsy, r2_tsz;
    logic [PGF_GAIN_W+PGF_MASS_W-1:0] r2_gml, r2_gmh;
    logic signed [PGF_DIFF_W-1:0] r2_dx, r2_dy, r2_dz;
    logic                         r2_same;
    // stage 3
    logic                         r3_vld;
    logic [PGF_D2_W-1:0]          r3_d2;
    logic [2*PGF_POS_W-1:0]       r3_t2;
    logic [PGF_GAIN_W+2*PGF_MASS_W-1:0] r3_gm;
    logic [2*PGF_RAD_W+1:0]       r3_rs2;
    logic signed [PGF_DIFF_W-1:0] r3_dx, r3_dy, r3_dz;
    logic                         r3_same;
    // stage 4
    logic                         r4_vld;
    t_sqrt_tag                    r4_data;

    logic [2*PGF_MASS_W-1:0]          w_mass;
    logic signed [2*PGF_DIFF_W-1:0]   w_sqx, w_sqy, w_sqz;
    logic signed [2*PGF_POS_W-1:0]    w_tsx, w_tsy, w_tsz;
    logic [2*PGF_RAD_W+1:0]           w_rs2;
    logic [PGF_GAIN_W+PGF_MASS_W-1:0] w_gml, w_gmh;
    logic                             w_coll;

    assign w_mass = i_target_mass * i_source_mass;
    assign w_sqx  = r1_dx * r1_dx;
    assign w_sqy  = r1_dy * r1_dy;
    assign w_sqz  = r1_dz * r1_dz;
    assign w_tsx  = r1_tx * r1_tx;
    assign w_tsy  = r1_ty * r1_ty;
    assign w_tsz  = r1_tz * r1_tz;
    assign w_rs2  = r1_rsum * r1_rsum;
    assign w_gml  = i_grav_gain * r1_mass[PGF_MASS_W-1:0];
    assign w_gmh  = i_grav_gain * r1_mass[2*PGF_MASS_W-1:PGF_MASS_W];
    assign w_coll = !r3_same && (r3_d2 < PGF_D2_W'(r3_rs2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_dx   <= PGF_DIFF_W'(i_target_x) - PGF_DIFF_W'(i_source_x);
            r1_dy   <= PGF_DIFF_W'(i_target_y) - PGF_DIFF_W'(i_source_y);
            r1_dz   <= PGF_DIFF_W'(i_target_z) - PGF_DIFF_W'(i_source_z);
            r1_same <= (i_target_id == i_source_id);
            r1_rsum <= {1'b0, i_target_radius} + {1'b0, i_source_radius};
            r1_tx   <= i_target_x;
            r1_ty   <= i_target_y;
            r1_tz   <= i_target_z;
            r1_mass <= w_mass;

            r2_sqx  <= w_sqx[2*PGF_POS_W:0];
            r2_sqy  <= w_sqy[2*PGF_POS_W:0];
            r2_sqz  <= w_sqz[2*PGF_POS_W:0];
            r2_tsx  <= w_tsx[2*PGF_POS_W-2:0];
            r2_tsy  <= w_tsy[2*PGF_POS_W-2:0];
            r2_tsz  <= w_tsz[2*PGF_POS_W-2:0];
            r2_rs2  <= w_rs2;
            r2_gml  <= w_gml;
            r2_gmh  <= w_gmh;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_dz   <= r1_dz;
            r2_same <= r1_same;

            r3_d2   <= PGF_D2_W'(r2_sqx) + PGF_D2_W'(r2_sqy) + PGF_D2_W'(r2_sqz);
            r3_t2   <= (2*PGF_POS_W)'(r2_tsx) + (2*PGF_POS_W)'(r2_tsy)
                     + (2*PGF_POS_W)'(r2_tsz);
            r3_gm   <= {{PGF_MASS_W{1'b0}}, r2_gml} + {r2_gmh, {PGF_MASS_W{1'b0}}};
            r3_rs2  <= r2_rs2;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_dz   <= r2_dz;
            r3_same <= r2_same;

            r4_data.d2                <= r3_d2;
            r4_data.num               <= {r3_gm, 16'd0};
            r4_data.dx                <= r3_dx;
            r4_data.dy                <= r3_dy;
            r4_data.dz                <= r3_dz;
            r4_data.flags.collided    <= w_coll;
            r4_data.flags.force_valid <= !r3_same && !w_coll && (r3_d2 != '0);
            r4_data.flags.escaped     <= r3_t2 >= (2*PGF_POS_W)'(i_esc_sq);
        end
    end

    assign o_vld  = r4_vld;
    assign o_data = r4_data;

endmodule

FILE: rtl/pgf_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with side data.
// No package dependencies.
module pgf_sqrt_pipe #(
    parameter int IN_W  = 66,
    parameter int TAG_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_vld,
    input  logic [IN_W-1:0]      i_val,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_vld,
    output logic [IN_W/2-1:0]    o_root,
    output logic [TAG_W-1:0]     o_tag
);
    localparam int STEPS  = IN_W / 2;
    localparam int ROOT_W = STEPS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CUR_W  = REM_W + 2;

    logic              r_vld  [STEPS];
    logic [IN_W-1:0]   r_v    [STEPS];
    logic [REM_W-1:0]  r_rem  [STEPS];
    logic [ROOT_W-1:0] r_root [STEPS];
    logic [TAG_W-1:0]  r_tag  [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic              c_vld;
        logic [IN_W-1:0]   c_v;
        logic [REM_W-1:0]  c_rem;
        logic [ROOT_W-1:0] c_root;
        logic [TAG_W-1:0]  c_tag;
        logic [CUR_W-1:0]  w_cur;
        logic [CUR_W-1:0]  w_trial;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign c_vld  = i_vld;
            assign c_v    = i_val;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_tag  = i_tag;
        end else begin : g_next
            assign c_vld  = r_vld[s-1];
            assign c_v    = r_v[s-1];
            assign c_rem  = r_rem[s-1];
            assign c_root = r_root[s-1];
            assign c_tag  = r_tag[s-1];
        end

        assign w_cur   = {c_rem, c_v[IN_W-1 -: 2]};
        assign w_trial = CUR_W'({c_root, 2'b01});
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ce) begin
                r_vld[s] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_v[s]    <= c_v << 2;
                r_rem[s]  <= w_ge ? REM_W'(w_cur - w_trial) : REM_W'(w_cur);
                r_root[s] <= ROOT_W'({c_root, w_ge});
                r_tag[s]  <= c_tag;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_root = r_root[STEPS-1];
    assign o_tag  = r_tag[STEPS-1];

endmodule

FILE: rtl/pgf_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// and side data. No package dependencies.
module pgf_div_pipe #(
    parameter int NUM_W = 112,
    parameter int DEN_W = 66,
    parameter int Q_W   = 81,
    parameter int TAG_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_vld,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [TAG_W-1:0]   i_tag,
    output logic               o_vld,
    output logic               o_ovf,
    output logic [Q_W-1:0]     o_quo,
    output logic [TAG_W-1:0]   o_tag
);
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic             r_vld [Q_W+1];
    logic             r_ovf [Q_W+1];
    logic [DEN_W-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0]   r_low [Q_W+1];
    logic [Q_W-1:0]   r_quo [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic [TAG_W-1:0] r_tag [Q_W+1];

    logic [HI_W-1:0]  w_hi;
    logic             w_ovf;

    // quotient fits in Q_W bits unless the top part already reaches the divisor
    assign w_hi  = i_num[NUM_W-1:Q_W];
    assign w_ovf = CMP_W'(w_hi) >= CMP_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ovf[0] <= w_ovf;
            r_rem[0] <= DEN_W'(w_hi);
            r_low[0] <= i_num[Q_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar s = 1; s <= Q_W; s++) begin : g_step
        logic [DEN_W:0] w_cur;
        logic           w_ge;

        assign w_cur = {r_rem[s-1], r_low[s-1][Q_W-1]};
        assign w_ge  = (w_cur >= {1'b0, r_den[s-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ce) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_ovf[s] <= r_ovf[s-1];
                r_rem[s] <= w_ge ? DEN_W'(w_cur - {1'b0, r_den[s-1]}) : DEN_W'(w_cur);
                r_low[s] <= r_low[s-1] << 1;
                r_quo[s] <= Q_W'({r_quo[s-1], w_ge});
                r_den[s] <= r_den[s-1];
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_vld = r_vld[Q_W];
    assign o_ovf = r_ovf[Q_W];
    assign o_quo = r_quo[Q_W];
    assign o_tag = r_tag[Q_W];

endmodule

FILE: rtl/pgf_axis.sv
// One force component: |d| * FM, divide by the distance, saturate and sign.
// Depends on pgf_pkg and pgf_div_pipe.
module pgf_axis (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_ce,
    input  logic                                  i_vld,
    input  logic [pgf_pkg::PGF_FM_W-1:0]          i_fm,
    input  logic [pgf_pkg::PGF_ROOT_W-1:0]        i_dr,
    input  logic signed [pgf_pkg::PGF_DIFF_W-1:0] i_d,
    input  pgf_pkg::t_flags                       i_flags,
    output logic                                  o_vld,
    output logic signed [pgf_pkg::PGF_FORCE_W-1:0] o_force,
    output pgf_pkg::t_flags                       o_flags
);
    import pgf_pkg::*;

    localparam int CH_W  = 28;
    localparam int TOP_W = PGF_FM_W - 2 * CH_W;
    localparam logic [PGF_FORCE_W-1:0] POS_LIM = {1'b0, {(PGF_FORCE_W-1){1'b1}}};
    localparam logic [PGF_FORCE_W-1:0] NEG_LIM = {1'b1, {(PGF_FORCE_W-1){1'b0}}};

    // A1: magnitude of the separation
    logic                     r1_vld;
    logic [PGF_DIFF_W-1:0]    r1_mag;
    logic [PGF_FM_W-1:0]      r1_fm;
    logic [PGF_ROOT_W-1:0]    r1_dr;
    t_axis_tag                r1_tag;
    // A2: partial products
    logic                          r2_vld;
    logic [CH_W+PGF_DIFF_W-1:0]    r2_p0, r2_p1;
    logic [TOP_W+PGF_DIFF_W-1:0]   r2_p2;
    logic [PGF_ROOT_W-1:0]         r2_dr;
    t_axis_tag                     r2_tag;
    // A3: full product
    logic                     r3_vld;
    logic [PGF_P_W-1:0]       r3_p;
    logic [PGF_ROOT_W-1:0]    r3_dr;
    t_axis_tag                r3_tag;
    // final
    logic                          r_vld;
    logic signed [PGF_FORCE_W-1:0] r_force;
    t_flags                        r_flags;

    logic                        w_dvld, w_dovf;
    logic [PGF_FORCE_W-1:0]      w_quo;
    logic [$bits(t_axis_tag)-1:0] w_dtag;
    t_axis_tag                   w_tag;
    logic [PGF_FORCE_W-1:0]      w_mag;
    logic signed [PGF_FORCE_W-1:0] w_force;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_mag            <= i_d[PGF_DIFF_W-1] ? PGF_DIFF_W'(-i_d) : PGF_DIFF_W'(i_d);
            r1_fm             <= i_fm;
            r1_dr             <= i_dr;
            r1_tag.neg        <= i_d[PGF_DIFF_W-1];
            r1_tag.kill       <= (i_d == '0) || !i_flags.force_valid;
            r1_tag.flags      <= i_flags;

            r2_p0  <= r1_fm[CH_W-1:0] * r1_mag;
            r2_p1  <= r1_fm[2*CH_W-1:CH_W] * r1_mag;
            r2_p2  <= r1_fm[PGF_FM_W-1:2*CH_W] * r1_mag;
            r2_dr  <= r1_dr;
            r2_tag <= r1_tag;

            r3_p   <= PGF_P_W'(r2_p0) + (PGF_P_W'(r2_p1) << CH_W)
                    + (PGF_P_W'(r2_p2) << (2 * CH_W));
            r3_dr  <= r2_dr;
            r3_tag <= r2_tag;
        end
    end

    pgf_div_pipe #(
        .NUM_W (PGF_P_W),
        .DEN_W (PGF_ROOT_W),
        .Q_W   (PGF_FORCE_W),
        .TAG_W ($bits(t_axis_tag))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (i_ce),
        .i_vld   (r3_vld),
        .i_num   (r3_p),
        .i_den   (r3_dr),
        .i_tag   (r3_tag),
        .o_vld   (w_dvld),
        .o_ovf   (w_dovf),
        .o_quo   (w_quo),
        .o_tag   (w_dtag)
    );

    assign w_tag = t_axis_tag'(w_dtag);

    // negative separation pulls toward positive force, and the other way round
    always_comb begin
        if (w_tag.neg) begin
            w_mag   = (w_dovf || (w_quo > POS_LIM)) ? POS_LIM : w_quo;
            w_force = $signed(w_mag);
        end else begin
            w_mag   = (w_dovf || (w_quo > NEG_LIM)) ? NEG_LIM : w_quo;
            w_force = $signed(PGF_FORCE_W'(-w_mag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= w_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_force <= w_tag.kill ? '0 : w_force;
            r_flags <= w_tag.flags;
        end
    end

    assign o_vld   = r_vld;
    assign o_force = r_force;
    assign o_flags = r_flags;

endmodule

FILE: rtl/pairwise_gravity_force_core.sv
// Top level of the pairwise gravity force core: configuration registers,
// pipeline stitching and output skid. Depends on pgf_pkg, pgf_if and submodules.
//
// Takes one body pair per clock while i_in.ready is high and returns, in order,
// the attractive force on the target (saturated signed 48-bit, Q32.16) with
// force_valid, collided and escaped flags. Throughput is one pair per cycle
// unless the skid entry is full. An accepted request passes 4 front stages, 33
// square-root stages, 82 stages for the force magnitude divide, then per axis 3
// multiply stages, 49 divide stages and one saturation stage, and the output
// register; the two bit-serial dividers set most of that depth. The whole
// pipeline advances together; the output register and one skid entry keep it
// moving while one result waits, and i_in.ready drops once the skid entry fills.
// Configuration writes are accepted at any time but must only be issued while
// no request is in flight.
`include "pairwise_gravity_force_core_assert.svh"

module pairwise_gravity_force_core #(
    parameter int ID_BITS = pgf_pkg::PGF_ID_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgf_in_if.sink      i_in,
    pgf_out_if.source   o_out,
    pgf_cfg_if.sink     i_cfg
);
    import pgf_pkg::*;

    localparam logic [PGF_FM_W-1:0] FM_CAP = {1'b1, {PGF_FM_QW{1'b0}}};

    // configuration
    logic [PGF_GAIN_W-1:0]   r_grav;
    logic [PGF_ESC_W-1:0]    r_esc;
    logic [PGF_ESC_SQ_W-1:0] r_esc_sq;

    // pipeline enable: stop only when the skid entry is occupied
    logic ce;

    logic        front_vld;
    t_sqrt_tag   front_data;
    logic        sq_vld;
    logic [PGF_ROOT_W-1:0]       sq_root;
    logic [$bits(t_sqrt_tag)-1:0] sq_tag_bits;
    t_sqrt_tag   sq_tag;
    t_fmdiv_tag  fm_in_tag;
    logic        fm_vld, fm_ovf;
    logic [PGF_FM_QW-1:0]         fm_quo;
    logic [$bits(t_fmdiv_tag)-1:0] fm_tag_bits;
    t_fmdiv_tag  fm_tag;
    logic [PGF_FM_W-1:0]          fm;

    logic        x_vld;
    logic signed [PGF_FORCE_W-1:0] x_force, y_force, z_force;
    t_flags      x_flags;

    // output register and skid entry
    logic        r_out_valid, r_skid_valid;
    t_result     r_out, r_skid;
    t_result     tail;
    logic        tail_push, out_take;

    //------------------------------------------------------------------
    // configuration port, always ready
    //------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= PGF_GAIN_W'(1);
            r_esc  <= {1'b1, {(PGF_ESC_W-1){1'b0}}};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GRAV_GAIN:     r_grav <= i_cfg.data;
                CFG_ESCAPE_RADIUS: r_esc  <= i_cfg.data[PGF_ESC_W-1:0];
                default: ;  // unknown register, write dropped
            endcase
        end
    end

    // escape threshold squared, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_esc_sq <= r_esc * r_esc;
    end

    assign ce         = !r_skid_valid;
    assign i_in.ready = ce;

    //------------------------------------------------------------------
    // datapath
    //------------------------------------------------------------------
    pgf_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ce            (ce),
        .i_vld           (i_in.valid),
        .i_target_id     (i_in.target_id),
        .i_source_id     (i_in.source_id),
        .i_target_x      (i_in.target_x),
        .i_target_y      (i_in.target_y),
        .i_target_z      (i_in.target_z),
        .i_source_x      (i_in.source_x),
        .i_source_y      (i_in.source_y),
        .i_source_z      (i_in.source_z),
        .i_target_mass   (i_in.target_mass),
        .i_source_mass   (i_in.source_mass),
        .i_target_radius (i_in.target_radius),
        .i_source_radius (i_in.source_radius),
        .i_grav_gain     (r_grav),
        .i_esc_sq        (r_esc_sq),
        .o_vld           (front_vld),
        .o_data          (front_data)
    );

    // DR = floor(sqrt(D2))
    pgf_sqrt_pipe #(
        .IN_W  (PGF_D2_W),
        .TAG_W ($bits(t_sqrt_tag))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (front_vld),
        .i_val   (front_data.d2),
        .i_tag   (front_data),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag_bits)
    );

    assign sq_tag          = t_sqrt_tag'(sq_tag_bits);
    assign fm_in_tag.dr    = sq_root;
    assign fm_in_tag.dx    = sq_tag.dx;
    assign fm_in_tag.dy    = sq_tag.dy;
    assign fm_in_tag.dz    = sq_tag.dz;
    assign fm_in_tag.flags = sq_tag.flags;

    // FM = floor(G * m_t * m_s * 2^16 / D2); anything at or above 2^81
    // saturates every nonzero component, so it is clamped there
    pgf_div_pipe #(
        .NUM_W (PGF_NUM_W),
        .DEN_W (PGF_D2_W),
        .Q_W   (PGF_FM_QW),
        .TAG_W ($bits(t_fmdiv_tag))
    ) u_fm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (sq_vld),
        .i_num   (sq_tag.num),
        .i_den   (sq_tag.d2),
        .i_tag   (fm_in_tag),
        .o_vld   (fm_vld),
        .o_ovf   (fm_ovf),
        .o_quo   (fm_quo),
        .o_tag   (fm_tag_bits)
    );

    assign fm_tag = t_fmdiv_tag'(fm_tag_bits);
    assign fm     = fm_ovf ? FM_CAP : {1'b0, fm_quo};

    // three identical axis lanes in lockstep; flags ride on the x lane
    pgf_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (fm_vld),
        .i_fm    (fm),
        .i_dr    (fm_tag.dr),
        .i_d     (fm_tag.dx),
        .i_flags (fm_tag.flags),
        .o_vld   (x_vld),
        .o_force (x_force),
        .o_flags (x_flags)
    );

    pgf_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (fm_vld),
        .i_fm    (fm),
        .i_dr    (fm_tag.dr),
        .i_d     (fm_tag.dy),
        .i_flags (fm_tag.flags),
        .o_vld   (),
        .o_force (y_force),
        .o_flags ()
    );

    pgf_axis u_axis_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (fm_vld),
        .i_fm    (fm),
        .i_dr    (fm_tag.dr),
        .i_d     (fm_tag.dz),
        .i_flags (fm_tag.flags),
        .o_vld   (),
        .o_force (z_force),
        .o_flags ()
    );

    //------------------------------------------------------------------
    // output register with one skid entry
    //------------------------------------------------------------------
    assign tail.force_x = x_force;
    assign tail.force_y = y_force;
    assign tail.force_z = z_force;
    assign tail.flags   = x_flags;

    assign tail_push = ce && x_vld;
    assign out_take  = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= tail_push;
        end else if (tail_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            r_out <= tail;
        end else if (tail_push) begin
            r_skid <= tail;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.force_x     = r_out.force_x;
    assign o_out.force_y     = r_out.force_y;
    assign o_out.force_z     = r_out.force_z;
    assign o_out.force_valid = r_out.flags.force_valid;
    assign o_out.collided    = r_out.flags.collided;
    assign o_out.escaped     = r_out.flags.escaped;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    `PGF_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry holds a result while output register is empty")

    `PGF_ASSERT_IMP(a_flags_exclusive, i_clk, i_rst_n, r_out_valid,
        !(r_out.flags.force_valid && r_out.flags.collided),
        "result both valid and collided")

    `PGF_ASSERT_IMP(a_zero_when_invalid, i_clk, i_rst_n,
        r_out_valid && !r_out.flags.force_valid,
        (r_out.force_x == '0) && (r_out.force_y == '0) && (r_out.force_z == '0),
        "nonzero force on an invalid result")

    `PGF_ASSERT_NXT(a_tail_held, i_clk, i_rst_n, x_vld && !ce, x_vld,
        "pipeline tail lost a result during stall")

endmodule

FILE: dv/pairwise_gravity_force_core_test.sv
// Stand-alone testbench for pairwise_gravity_force_core: directed pair table, then random
// phases over several register settings, checked against an in-bench force predictor.
// Depends on pgf_pkg, pgf_if and the core RTL.
`timescale 1ns / 1ps

module pairwise_gravity_force_core_test;
    import pgf_pkg::*;

    localparam int RANDOM_PER_PHASE = 215;
    localparam int NUM_PHASES       = 8;
    localparam int DRAIN_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam logic [PGF_CFG_IDX_W-1:0] CFG_UNMAPPED_IDX = 8'hA5;

    typedef struct {
        logic [PGF_ID_BITS-1:0]       tid;
        logic [PGF_ID_BITS-1:0]       sid;
        logic signed [PGF_POS_W-1:0]  tx, ty, tz;
        logic signed [PGF_POS_W-1:0]  sx, sy, sz;
        logic [PGF_MASS_W-1:0]        tm, sm;
        logic [PGF_RAD_W-1:0]         tr, sr;
    } t_pair_req;

    typedef struct {
        t_pair_req req;
        bit        typed;   // expected result written by hand
        t_result   res;
    } t_pair_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pgf_in_if  in_if();
    pgf_out_if out_if();
    pgf_cfg_if cfg_if();

    pairwise_gravity_force_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [PGF_GAIN_W-1:0] gain_reg = 32'd1;
    logic [PGF_ESC_W-1:0]  esc_reg  = 31'h4000_0000;

    t_result   force_queue[$];
    int        err_count   = 0;
    int        checked     = 0;
    int        n_valid     = 0;
    int        n_collided  = 0;
    int        n_escaped   = 0;
    int        n_saturated = 0;
    bit        idle_en     = 1'b1;
    t_pair_row dir_table[$];

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] exp);
        err_count++;
        $display("mismatch @%0t result %0d %s: got %h expected %h",
                 $realtime, checked, what, got, exp);
    endtask

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [34:0] root_floor(input logic [67:0] v);
        logic [34:0] r;
        logic [34:0] t;
        logic [69:0] sq;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            t  = r | (35'd1 << b);
            sq = {35'd0, t} * {35'd0, t};
            if (sq <= {2'b0, v}) r = t;
        end
        return r;
    endfunction

    // one force component: magnitude FM*|d|/DR, sign opposite to d, saturated to 48 bits
    function automatic logic [47:0] axis_force(input logic [95:0] fm,
                                               input logic signed [32:0] d,
                                               input logic [34:0] dr);
        logic [159:0] num;
        logic [159:0] q;
        logic [47:0]  mag;
        if (d == 0) return '0;
        num = {64'd0, fm} * {127'd0, abs33(d)};
        q   = num / {125'd0, dr};
        if (d > 0) begin
            mag = (q > 160'h8000_0000_0000) ? 48'h8000_0000_0000 : q[47:0];
            return 48'd0 - mag;
        end
        return (q > 160'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : q[47:0];
    endfunction

    function automatic t_result pair_force(input t_pair_req r);
        t_result            res;
        logic signed [32:0] dx, dy, dz;
        logic [32:0]        ax, ay, az;
        logic [67:0]        d2, t2, rs2, esc2;
        logic [31:0]        rsum;
        logic [159:0]       num, fm;
        logic [34:0]        dr;
        bit                 same, coll, valid;
        same = r.tid == r.sid;
        dx = {r.tx[31], r.tx} - {r.sx[31], r.sx};
        dy = {r.ty[31], r.ty} - {r.sy[31], r.sy};
        dz = {r.tz[31], r.tz} - {r.sz[31], r.sz};
        d2 = {35'd0, abs33(dx)} * {35'd0, abs33(dx)} + {35'd0, abs33(dy)} * {35'd0, abs33(dy)}
           + {35'd0, abs33(dz)} * {35'd0, abs33(dz)};
        ax = abs33({r.tx[31], r.tx});
        ay = abs33({r.ty[31], r.ty});
        az = abs33({r.tz[31], r.tz});
        t2 = {35'd0, ax} * {35'd0, ax} + {35'd0, ay} * {35'd0, ay} + {35'd0, az} * {35'd0, az};
        esc2 = {37'd0, esc_reg} * {37'd0, esc_reg};
        rsum = {1'b0, r.tr} + {1'b0, r.sr};
        rs2  = {36'd0, rsum} * {36'd0, rsum};
        coll  = !same && d2 < rs2;
        valid = !same && !coll && d2 != 0;
        res = '0;
        res.flags.force_valid = valid;
        res.flags.collided    = coll;
        res.flags.escaped     = t2 >= esc2;
        if (valid) begin
            dr  = root_floor(d2);
            num = ({128'd0, gain_reg} * {128'd0, r.tm} * {128'd0, r.sm}) << 16;
            fm  = num / {92'd0, d2};
            if (fm > (160'd1 << 95)) fm = 160'd1 << 95;
            res.force_x = axis_force(fm[95:0], dx, dr);
            res.force_y = axis_force(fm[95:0], dy, dr);
            res.force_z = axis_force(fm[95:0], dz, dr);
        end
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        if (!idle_en) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_pair(input t_pair_req r, input bit typed, input t_result res);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.target_id     = r.tid;
        in_if.source_id     = r.sid;
        in_if.target_x      = r.tx;
        in_if.target_y      = r.ty;
        in_if.target_z      = r.tz;
        in_if.source_x      = r.sx;
        in_if.source_y      = r.sy;
        in_if.source_z      = r.sz;
        in_if.target_mass   = r.tm;
        in_if.source_mass   = r.sm;
        in_if.target_radius = r.tr;
        in_if.source_radius = r.sr;
        in_if.valid         = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        force_queue.insert(force_queue.size(), typed ? res : pair_force(r));
    endtask

    task automatic write_reg(input logic [PGF_CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_if.index = idx;
        cfg_if.data  = data;
        cfg_if.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_GRAV_GAIN) gain_reg = data;
        else if (idx == CFG_ESCAPE_RADIUS) esc_reg = data[30:0];
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // wait until every request has its result, then let the pipe run dry
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (force_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    function automatic t_pair_req rand_pair();
        t_pair_req r;
        int        kind;
        kind  = $urandom_range(0, 99);
        r.tid = PGF_ID_BITS'($urandom_range(0, 1023));
        r.sid = (kind < 8) ? r.tid : PGF_ID_BITS'($urandom_range(0, 1023));
        if (kind < 50) begin
            r.tx = $urandom; r.ty = $urandom; r.tz = $urandom;
        end else begin
            r.tx = rand_coord(); r.ty = rand_coord(); r.tz = rand_coord();
        end
        if ($urandom_range(0, 99) < 35) begin
            r.sx = $urandom; r.sy = $urandom; r.sz = $urandom;
        end else begin
            // a near neighbor: small offsets, sometimes zero on an axis
            r.sx = r.tx + ($signed($urandom) >>> $urandom_range(8, 31));
            r.sy = r.ty + ($signed($urandom) >>> $urandom_range(8, 31));
            r.sz = r.tz + ($signed($urandom) >>> $urandom_range(8, 31));
        end
        r.tm = $urandom >> $urandom_range(0, 31);
        r.sm = $urandom >> $urandom_range(0, 31);
        r.tr = PGF_RAD_W'($urandom >> $urandom_range(1, 32));
        r.sr = PGF_RAD_W'($urandom >> $urandom_range(1, 32));
        return r;
    endfunction

    function automatic t_pair_req pair_at(input int tid, input int sid,
                                          input logic [31:0] tx, input logic [31:0] ty,
                                          input logic [31:0] tz, input logic [31:0] sx,
                                          input logic [31:0] sy, input logic [31:0] sz,
                                          input logic [31:0] tm, input logic [31:0] sm,
                                          input logic [30:0] tr, input logic [30:0] sr);
        t_pair_req r;
        r.tid = PGF_ID_BITS'(tid); r.sid = PGF_ID_BITS'(sid);
        r.tx = tx; r.ty = ty; r.tz = tz;
        r.sx = sx; r.sy = sy; r.sz = sz;
        r.tm = tm; r.sm = sm; r.tr = tr; r.sr = sr;
        return r;
    endfunction

    function automatic void add_row(input t_pair_req r, input bit typed,
                                    input bit fv, input bit col, input bit esc);
        t_pair_row row;
        row.req   = r;
        row.typed = typed;
        row.res   = '0;
        row.res.flags.force_valid = fv;
        row.res.flags.collided    = col;
        row.res.flags.escaped     = esc;
        dir_table.insert(dir_table.size(), row);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result exp;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (force_queue.size() == 0) begin
                report("unexpected result", 48'd0, 48'd0);
            end else begin
                exp = force_queue.pop_front();
                if (out_if.force_x !== exp.force_x) report("force_x", out_if.force_x, exp.force_x);
                if (out_if.force_y !== exp.force_y) report("force_y", out_if.force_y, exp.force_y);
                if (out_if.force_z !== exp.force_z) report("force_z", out_if.force_z, exp.force_z);
                if (out_if.force_valid !== exp.flags.force_valid)
                    report("force_valid", 48'(out_if.force_valid), 48'(exp.flags.force_valid));
                if (out_if.collided !== exp.flags.collided)
                    report("collided", 48'(out_if.collided), 48'(exp.flags.collided));
                if (out_if.escaped !== exp.flags.escaped)
                    report("escaped", 48'(out_if.escaped), 48'(exp.flags.escaped));
                n_valid    += exp.flags.force_valid;
                n_collided += exp.flags.collided;
                n_escaped  += exp.flags.escaped;
                if (exp.force_x == 48'h8000_0000_0000 || exp.force_x == 48'h7FFF_FFFF_FFFF)
                    n_saturated++;
            end
            checked++;
        end
    end

    // receiver back-pressure, changed on the falling edge
    initial begin
        int gap;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = 1'b1;
            if (idle_en && $urandom_range(0, 99) < 25) begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_if.ready = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                    || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         quiet, force_queue.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [31:0] gains[NUM_PHASES];
        logic [31:0] escs[NUM_PHASES];
        t_result     blank;
        int          n_sent;

        in_if.valid = 1'b0;
        in_if.target_id = '0;      in_if.source_id = '0;
        in_if.target_x = '0;       in_if.target_y = '0;      in_if.target_z = '0;
        in_if.source_x = '0;       in_if.source_y = '0;      in_if.source_z = '0;
        in_if.target_mass = '0;    in_if.source_mass = '0;
        in_if.target_radius = '0;  in_if.source_radius = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_GRAV_GAIN;
        cfg_if.data  = '0;
        blank = '0;
        n_sent = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed pairs at reset settings (gain 1, escape radius 16384.0)
        // same identifier at the origin: nothing at all
        add_row(pair_at(5, 5, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), 1, 0, 0, 0);
        // same identifier, target exactly on the escape radius
        add_row(pair_at(7, 7, 32'h4000_0000, 0, 0, 1, 2, 3, 9, 9, 0, 0), 1, 0, 0, 1);
        // just inside the escape radius
        add_row(pair_at(8, 8, 32'h3FFF_FFFF, 0, 0, 0, 0, 0, 1, 1, 0, 0), 1, 0, 0, 0);
        // overlapping distinct bodies at one point
        add_row(pair_at(1, 2, 0, 0, 0, 0, 0, 0, 100, 100, 1, 1), 1, 0, 1, 0);
        // coincident bodies with zero radii
        add_row(pair_at(1, 2, 16, 16, 16, 16, 16, 16, 100, 100, 0, 0), 1, 0, 0, 0);
        // both at the origin with maximal radii: the widest radius sum overlaps
        add_row(pair_at(0, 1023, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 31'h7FFF_FFFF,
                        31'h7FFF_FFFF), 1, 0, 1, 0);
        // opposite corners, extreme positions, masses and radii
        add_row(pair_at(1023, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, 0, 0, 0);
        add_row(pair_at(0, 1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), 0, 0, 0, 0);
        // one unit apart on a single axis, heavy: saturates, other axes zero
        add_row(pair_at(3, 4, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), 0, 0, 0, 0);
        add_row(pair_at(3, 4, 0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), 0, 0, 0, 0);
        add_row(pair_at(3, 4, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h1, 0, 0),
                0, 0, 0, 0);
        // separation exactly equals the radius sum: touching is not an overlap
        add_row(pair_at(9, 10, 32'h0003_0000, 0, 0, 0, 32'h0004_0000, 0, 1000, 1000,
                        31'h0002_0000, 31'h0003_0000), 0, 0, 0, 0);
        // zero mass: valid force of zero
        add_row(pair_at(11, 12, 32'h0010_0000, 32'hFFF0_0000, 32'h0001_0000, 0, 0, 0, 0,
                        32'hFFFF_FFFF, 1, 1), 0, 0, 0, 0);
        // ordinary pair with all components nonzero
        add_row(pair_at(20, 21, 32'h0012_3456, 32'hFFED_CBA9, 32'h0000_8000,
                        32'hFFF0_0000, 32'h0020_0000, 32'hFFFF_0000, 32'h00FF_FFFF,
                        32'h0FFF_FFFF, 31'h100, 31'h200), 0, 0, 0, 0);
        foreach (dir_table[i]) send_pair(dir_table[i].req, dir_table[i].typed, dir_table[i].res);
        n_sent += dir_table.size();
        drain();

        // settings per phase; extremes first, then random
        gains[0] = 32'd1;          escs[0] = 32'h4000_0000;
        gains[1] = 32'd0;          escs[1] = 32'd0;
        gains[2] = 32'hFFFF_FFFF;  escs[2] = 32'h7FFF_FFFF;
        gains[3] = 32'hFFFF_FFFF;  escs[3] = 32'h0001_0000;
        gains[4] = 32'h0001_0000;  escs[4] = $urandom & 32'h7FFF_FFFF;
        for (int p = 5; p < NUM_PHASES; p++) begin
            gains[p] = $urandom >> $urandom_range(0, 31);
            escs[p]  = ($urandom >> 1) >> $urandom_range(0, 31);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_GRAV_GAIN, gains[p]);
            write_reg(CFG_ESCAPE_RADIUS, escs[p]);
            // an unmapped register must leave both settings alone
            if (p == 2) write_reg(CFG_UNMAPPED_IDX, $urandom);
            idle_en = (p != 3);   // one phase runs at full rate both ways
            for (int k = 0; k < RANDOM_PER_PHASE; k++) send_pair(rand_pair(), 0, blank);
            n_sent += RANDOM_PER_PHASE;
            drain();
        end

        $display("%0d pairs over %0d register settings, %0d results checked", n_sent,
                 NUM_PHASES + 1, checked);
        $display("force valid %0d, collided %0d, escaped %0d, saturated x %0d",
                 n_valid, n_collided, n_escaped, n_saturated);
        if (err_count == 0 && force_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, force_queue.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pgf_pkg.sv
rtl/pgf_if.sv
rtl/pgf_front.sv
rtl/pgf_sqrt_pipe.sv
rtl/pgf_div_pipe.sv
rtl/pgf_axis.sv
rtl/pairwise_gravity_force_core.sv
dv/pairwise_gravity_force_core_test.sv
